// File: design/adsr_envelope_generator_macros.svh
// Assertion macros for the ADSR envelope generator.
// Used by the top level; expects signals clk and rst in scope.
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property at every clock edge outside reset.
`define ADSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next.
`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ADSR_ASSERT(label, prop, msg)
`define ADSR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: design/adsr_pkg.sv
// Shared types and constants for the ADSR envelope generator.
// No dependencies; imported by every module of the block.
package adsr_pkg;

  localparam int LEVEL_FRACTION_BITS = 7;

  localparam int TICK_W  = 24;
  localparam int CNT_W   = 32;
  localparam int AMP_W   = 15;
  localparam int LEVEL_W = 8;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Multiplier and divider widths
  localparam int MAG_W  = CNT_W + 1;
  localparam int PROD_W = AMP_W + MAG_W;
  localparam int DIVD_W = AMP_W + TICK_W;
  localparam int QUO_W  = AMP_W + 1;
  localparam int QCNT_W = $clog2(QUO_W);

  localparam logic [AMP_W-1:0] FULL_SCALE = AMP_W'(255 << LEVEL_FRACTION_BITS);

  typedef enum logic [2:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_SUSTAIN = 3'd2,
    REG_RELEASE = 3'd3,
    REG_LEVEL   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [TICK_W-1:0]  attack_ticks;
    logic [TICK_W-1:0]  decay_ticks;
    logic [TICK_W-1:0]  sustain_ticks;
    logic [TICK_W-1:0]  release_ticks;
    logic [LEVEL_W-1:0] sustain_level;
  } cfg_t;

  typedef struct packed {
    logic trigger;
    logic release_request;
  } item_t;

  typedef struct packed {
    logic [AMP_W-1:0] amplitude;
    logic [2:0]       phase;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [TICK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: design/adsr_regs.sv
// APB register file for the envelope durations and sustain level.
// Depends on adsr_pkg.
module adsr_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [adsr_pkg::ADDR_W-1:0] paddr,
  input  logic [adsr_pkg::DATA_W-1:0] pwdata,
  output logic [adsr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output adsr_pkg::cfg_t              cfg
);
  import adsr_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_ticks  <= TICK_W'(1);
      cfg.decay_ticks   <= TICK_W'(1);
      cfg.sustain_ticks <= '0;
      cfg.release_ticks <= TICK_W'(1);
      cfg.sustain_level <= '1;
    end else if (wr_en) begin
      case (idx)
        REG_ATTACK:  cfg.attack_ticks  <= pwdata[TICK_W-1:0];
        REG_DECAY:   cfg.decay_ticks   <= pwdata[TICK_W-1:0];
        REG_SUSTAIN: cfg.sustain_ticks <= pwdata[TICK_W-1:0];
        REG_RELEASE: cfg.release_ticks <= pwdata[TICK_W-1:0];
        REG_LEVEL:   cfg.sustain_level <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ATTACK:  prdata = DATA_W'(cfg.attack_ticks);
      REG_DECAY:   prdata = DATA_W'(cfg.decay_ticks);
      REG_SUSTAIN: prdata = DATA_W'(cfg.sustain_ticks);
      REG_RELEASE: prdata = DATA_W'(cfg.release_ticks);
      REG_LEVEL:   prdata = DATA_W'(cfg.sustain_level);
      default:     prdata = '0;
    endcase
  end

endmodule

// File: design/adsr_div.sv
// Shared restoring divider: one quotient bit per cycle, saturating quotient.
// Depends on adsr_pkg.
module adsr_div (
  input  logic               clk,
  input  logic               rst,
  input  adsr_pkg::div_req_t req,
  output adsr_pkg::div_rsp_t rsp
);
  import adsr_pkg::*;

  logic              busy;
  logic              done;
  logic [QCNT_W-1:0] cnt;
  logic [TICK_W-1:0] rem;
  logic [QUO_W-1:0]  sh;
  logic              ovf;
  logic [TICK_W:0]   rem_sh;
  logic              q_bit;

  // Quotient would not fit: saturate instead of iterating
  assign ovf    = {1'b0, req.dividend[DIVD_W-1:QUO_W]} >= req.divisor;
  assign rem_sh = {rem, sh[QUO_W-1]};
  assign q_bit  = rem_sh >= {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= !ovf;
        done <= ovf;
        cnt  <= QCNT_W'(QUO_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= {1'b0, req.dividend[DIVD_W-1:QUO_W]};
      sh  <= ovf ? '1 : req.dividend[QUO_W-1:0];
    end else if (busy) begin
      rem <= q_bit ? TICK_W'(rem_sh - {1'b0, req.divisor}) : rem_sh[TICK_W-1:0];
      sh  <= {sh[QUO_W-2:0], q_bit};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = sh;

endmodule

// File: design/adsr_envelope_generator.sv
// Linear ADSR envelope generator, one input beat per envelope tick and one result beat
// back, configured over APB (durations at 0x0..0xC, sustain level at 0x10). An item goes
// straight to the finish when the level needs no division (sustain, done, ramp ends);
// otherwise it passes through the level multiply and the 16 steps of the shared restoring
// divider that follows it. The block takes the next beat only once the current one is
// finished; a finished result waits in the output register. Depends on adsr_pkg,
// adsr_regs, adsr_div and the macro header.
`include "adsr_envelope_generator_macros.svh"

module adsr_envelope_generator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [adsr_pkg::ADDR_W-1:0] paddr,
  input  logic [adsr_pkg::DATA_W-1:0] pwdata,
  output logic [adsr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  adsr_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output adsr_pkg::result_t           result
);
  import adsr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_DIVW = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_t state, state_next;

  phase_t           cur_phase;
  logic [CNT_W-1:0] elapsed;
  logic [AMP_W-1:0] held_level;

  // Work registers for the item in flight
  phase_t            ph_work;
  logic [CNT_W-1:0]  t_work;
  logic              direct;
  logic [AMP_W-1:0]  direct_amp;
  logic              dec_pos;
  logic              dec_neg;
  logic              sus_expire;
  logic [AMP_W-1:0]  mul_x;
  logic [MAG_W-1:0]  mul_y;
  logic [TICK_W-1:0] divisor;
  logic [PROD_W-1:0] prod;

  // Entry
  logic             accept;
  phase_t           ph_in;
  logic [CNT_W-1:0] t_in;

  // Operand setup
  logic [TICK_W-1:0] a_eff, d_eff, r_eff;
  logic [AMP_W-1:0]  s_lvl;
  logic [TICK_W:0]   sum_ad;
  logic [CNT_W+1:0]  k;
  logic [CNT_W+1:0]  k_abs;
  logic              k_neg;
  logic              k_ge_d;
  logic [TICK_W+1:0] sus_sum;
  logic              p_direct, p_pos, p_neg, p_expire;
  logic [AMP_W-1:0]  p_amp, p_x;
  logic [MAG_W-1:0]  p_y;
  logic [TICK_W-1:0] p_div;

  // Finish
  logic              commit;
  logic [QUO_W-1:0]  q;
  logic [QUO_W:0]    sum_q;
  logic [AMP_W-1:0]  amp;
  phase_t            ph_next;
  logic [AMP_W-1:0]  held_next;
  logic [CNT_W-1:0]  t_base;
  logic [CNT_W-1:0]  elapsed_next;

  adsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  adsr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign commit     = (state == S_FIN) && (!result_valid || result_ready);

  // Trigger first, then release request
  always_comb begin
    ph_in = item.trigger ? PH_ATTACK : cur_phase;
    t_in  = item.trigger ? '0 : elapsed;
    if (item.release_request && ph_in != PH_RELEASE && ph_in != PH_DONE) begin
      ph_in = PH_RELEASE;
      t_in  = '0;
    end
  end

  assign a_eff   = (cfg.attack_ticks  == '0) ? TICK_W'(1) : cfg.attack_ticks;
  assign d_eff   = (cfg.decay_ticks   == '0) ? TICK_W'(1) : cfg.decay_ticks;
  assign r_eff   = (cfg.release_ticks == '0) ? TICK_W'(1) : cfg.release_ticks;
  assign s_lvl   = AMP_W'(cfg.sustain_level) << LEVEL_FRACTION_BITS;
  assign sum_ad  = {1'b0, a_eff} + {1'b0, d_eff};
  assign k       = (CNT_W+2)'(sum_ad) - {2'b00, t_work};
  assign k_neg   = k[CNT_W+1];
  assign k_abs   = k_neg ? ((CNT_W+2)'(0) - k) : k;
  assign k_ge_d  = $signed(k) >= $signed({{(CNT_W+2-TICK_W){1'b0}}, d_eff});
  assign sus_sum = (TICK_W+2)'(cfg.sustain_ticks) + (TICK_W+2)'(d_eff)
                 + (TICK_W+2)'(a_eff);

  always_comb begin
    p_direct = 1'b1;
    p_amp    = '0;
    p_pos    = 1'b0;
    p_neg    = 1'b0;
    p_x      = '0;
    p_y      = '0;
    p_div    = a_eff;
    p_expire = (cfg.sustain_ticks != '0) && (t_work >= CNT_W'(sus_sum));
    case (ph_work)
      PH_ATTACK: begin
        p_direct = t_work >= CNT_W'(a_eff);
        p_amp    = FULL_SCALE;
        p_x      = FULL_SCALE;
        p_y      = MAG_W'(t_work[TICK_W-1:0]);
        p_div    = a_eff;
      end
      PH_DECAY: begin
        p_direct = k_ge_d;
        p_amp    = FULL_SCALE;
        p_x      = FULL_SCALE - s_lvl;
        p_y      = k_abs[MAG_W-1:0];
        p_pos    = !k_neg;
        p_neg    = k_neg;
        p_div    = d_eff;
      end
      PH_SUSTAIN: begin
        p_amp = s_lvl;
      end
      PH_RELEASE: begin
        p_direct = t_work >= CNT_W'(r_eff);
        p_x      = held_level;
        p_y      = MAG_W'(r_eff - t_work[TICK_W-1:0]);
        p_div    = r_eff;
      end
      default: ;
    endcase
  end

  // Saturate the product so the quotient only needs its low bits
  assign div_req.start    = (state == S_DIV);
  assign div_req.dividend = (|prod[PROD_W-1:DIVD_W]) ? '1 : prod[DIVD_W-1:0];
  assign div_req.divisor  = divisor;

  assign q     = div_rsp.quotient;
  assign sum_q = (QUO_W+1)'(s_lvl) + (QUO_W+1)'(q);

  always_comb begin
    if (direct) begin
      amp = direct_amp;
    end else if (dec_pos) begin
      amp = (sum_q > (QUO_W+1)'(FULL_SCALE)) ? FULL_SCALE : sum_q[AMP_W-1:0];
    end else if (dec_neg) begin
      amp = (q >= QUO_W'(s_lvl)) ? '0 : AMP_W'(s_lvl - q[AMP_W-1:0]);
    end else begin
      amp = (q > QUO_W'(FULL_SCALE)) ? FULL_SCALE : q[AMP_W-1:0];
    end
  end

  always_comb begin
    ph_next   = ph_work;
    held_next = held_level;
    t_base    = t_work;
    case (ph_work)
      PH_ATTACK: begin
        held_next = amp;
        ph_next   = direct ? PH_DECAY : PH_ATTACK;
      end
      PH_DECAY: begin
        held_next = amp;
        ph_next   = (amp <= s_lvl) ? PH_SUSTAIN : PH_DECAY;
      end
      PH_SUSTAIN: begin
        held_next = amp;
        if (sus_expire) begin
          ph_next = PH_RELEASE;
          t_base  = '0;
        end
      end
      PH_RELEASE: begin
        ph_next = (amp == '0) ? PH_DONE : PH_RELEASE;
      end
      default: begin
        ph_next = PH_DONE;
      end
    endcase
  end

  // Tick count holds at its top value
  assign elapsed_next = (&t_base) ? t_base : t_base + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_PREP;
      S_PREP: state_next = p_direct ? S_FIN : S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  state_next = S_DIVW;
      S_DIVW: if (div_rsp.done) state_next = S_FIN;
      S_FIN:  if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur_phase    <= PH_DONE;
      elapsed      <= '0;
      held_level   <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        cur_phase    <= ph_next;
        elapsed      <= elapsed_next;
        held_level   <= held_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ph_work <= ph_in;
      t_work  <= t_in;
    end
    if (state == S_PREP) begin
      direct     <= p_direct;
      direct_amp <= p_amp;
      dec_pos    <= p_pos;
      dec_neg    <= p_neg;
      sus_expire <= p_expire;
      mul_x      <= p_x;
      mul_y      <= p_y;
      divisor    <= p_div;
    end
    if (state == S_MUL) begin
      prod <= PROD_W'(mul_x) * PROD_W'(mul_y);
    end
    if (commit) begin
      result.amplitude <= amp;
      result.phase     <= ph_next;
    end
  end

  `ADSR_ASSERT_NEXT(a_one_at_a_time, item_valid && item_ready, !item_ready, "beat accepted while busy")
  `ADSR_ASSERT(a_amp_range, !result_valid || (result.amplitude <= FULL_SCALE), "amplitude above full scale")
  `ADSR_ASSERT(a_done_silent, !(result_valid && result.phase == PH_DONE) || (result.amplitude == '0), "done phase with nonzero amplitude")
  `ADSR_ASSERT(a_held_range, held_level <= FULL_SCALE, "held level above full scale")

endmodule

// File: dv/tb_adsr_envelope_generator.sv
// Self-checking bench for adsr_envelope_generator: APB register setup, tick beats in,
// level and phase beats out, each compared with a typed-in result or an in-bench envelope predictor.
// Depends on adsr_pkg and the design sources only.
module tb_adsr_envelope_generator;
  import adsr_pkg::*;

  localparam int DIR_ROWS     = 24;
  localparam int RECFG_ROW    = 12;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 140;
  localparam int MAX_GAP      = 100;
  localparam int SETTLE       = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;

  typedef struct packed {
    item_t   tick;
    logic    typed;
    result_t want;
  } dir_row_t;

  // First rows run on reset register values, so their results are typed in.
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{'{1'b0, 1'b0}, 1'b1, '{15'd0, PH_DONE}},
    '{'{1'b0, 1'b1}, 1'b1, '{15'd0, PH_DONE}},
    '{'{1'b1, 1'b0}, 1'b1, '{15'd0, PH_ATTACK}},
    '{'{1'b0, 1'b0}, 1'b1, '{FULL_SCALE, PH_DECAY}},
    '{'{1'b0, 1'b0}, 1'b1, '{FULL_SCALE, PH_SUSTAIN}},
    '{'{1'b0, 1'b0}, 1'b1, '{FULL_SCALE, PH_SUSTAIN}},
    '{'{1'b0, 1'b1}, 1'b1, '{FULL_SCALE, PH_RELEASE}},
    '{'{1'b0, 1'b1}, 1'b1, '{15'd0, PH_DONE}},
    '{'{1'b1, 1'b1}, 1'b1, '{FULL_SCALE, PH_RELEASE}},
    '{'{1'b0, 1'b0}, 1'b1, '{15'd0, PH_DONE}},
    '{'{1'b1, 1'b0}, 1'b1, '{15'd0, PH_ATTACK}},
    '{'{1'b1, 1'b0}, 1'b1, '{15'd0, PH_ATTACK}},
    '{'{1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b0, 1'b1}, 1'b0, '0}
  };

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              item_valid = 1'b0;
  logic              item_ready;
  item_t             item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  result_t           result;

  // Predictor state and register mirror
  cfg_t        cfg;
  phase_t      env_phase;
  logic [31:0] env_ticks;
  logic [15:0] env_held;

  result_t expected_levels [$];
  result_t level_due;
  int      mismatches = 0;
  int      tick_count = 0;
  int      results_seen = 0;
  int      reg_writes = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      hold_req = 0;
  int      hold_ack = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  adsr_envelope_generator uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clamp_level(longint v);
    if (v > longint'(FULL_SCALE)) return longint'(FULL_SCALE);
    if (v < 0) return 0;
    return v;
  endfunction

  function automatic longint ticks_or_one(logic [TICK_W-1:0] v);
    longint w;
    w = {40'd0, v};
    return (w == 0) ? 1 : w;
  endfunction

  function automatic result_t envelope_step(item_t it);
    longint  a, d, r, s, full, t, amp;
    result_t res;
    a    = ticks_or_one(cfg.attack_ticks);
    d    = ticks_or_one(cfg.decay_ticks);
    r    = ticks_or_one(cfg.release_ticks);
    s    = {56'd0, cfg.sustain_level} << LEVEL_FRACTION_BITS;
    full = {49'd0, FULL_SCALE};
    amp  = 0;
    if (it.trigger) begin
      env_ticks = '0;
      env_phase = PH_ATTACK;
    end
    if (it.release_request && env_phase != PH_RELEASE && env_phase != PH_DONE) begin
      env_phase = PH_RELEASE;
      env_ticks = '0;
    end
    t = {32'd0, env_ticks};
    case (env_phase)
      PH_ATTACK: begin
        amp = clamp_level(full * t / a);
        env_held = amp[15:0];
        if (t >= a) env_phase = PH_DECAY;
      end
      PH_DECAY: begin
        amp = clamp_level(s + ((full - s) * (a + d - t)) / d);
        env_held = amp[15:0];
        if (amp <= s) env_phase = PH_SUSTAIN;
      end
      PH_SUSTAIN: begin
        amp = clamp_level(s);
        env_held = amp[15:0];
        if (cfg.sustain_ticks != 0 && t >= {40'd0, cfg.sustain_ticks} + d + a) begin
          env_ticks = '0;
          env_phase = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        if (t >= r) amp = 0;
        else amp = clamp_level(({48'd0, env_held} * (r - t)) / r);
        if (amp <= 0) env_phase = PH_DONE;
      end
      default: begin
        env_phase = PH_DONE;
        amp = 0;
      end
    endcase
    // saturate the tick counter
    if (env_ticks != 32'hFFFF_FFFF) env_ticks = env_ticks + 1;
    res.amplitude = amp[AMP_W-1:0];
    res.phase     = env_phase;
    return res;
  endfunction

  function automatic logic [TICK_W-1:0] pick_ticks(int max_bits);
    return TICK_W'($urandom_range(1, (1 << $urandom_range(1, max_bits)) - 1));
  endfunction

  function automatic cfg_t pick_cfg(int kind);
    cfg_t c;
    int   bits;
    case (kind)
      1: c = '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 8'hFF};
      2: c = '{24'd0, 24'd0, 24'd0, 24'd0, 8'h00};
      default: begin
        bits = (kind == 3) ? TICK_W : 4;
        c.attack_ticks  = pick_ticks(bits);
        c.decay_ticks   = pick_ticks(bits);
        c.sustain_ticks = ($urandom_range(99) < 30) ? '0 : pick_ticks(bits);
        c.release_ticks = pick_ticks(bits);
        case ($urandom_range(9))
          0: c.sustain_level = 8'h00;
          1: c.sustain_level = 8'hFF;
          default: c.sustain_level = 8'($urandom);
        endcase
      end
    endcase
    return c;
  endfunction

  // Mostly plain ticks with occasional note events; some beats are raw noise.
  function automatic item_t pick_tick();
    item_t it;
    int    roll;
    roll = $urandom_range(99);
    if (roll < 15)      it = item_t'(2'($urandom_range(3)));
    else if (roll < 21) it = '{1'b1, 1'b0};
    else if (roll < 25) it = '{1'b0, 1'b1};
    else if (roll < 26) it = '{1'b1, 1'b1};
    else                it = '{1'b0, 1'b0};
    return it;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [TICK_W-1:0] val);
    logic [DATA_W-1:0] junk, word, want;
    junk = $urandom;
    if (idx == REG_LEVEL) begin
      want = {24'd0, val[7:0]};
      word = {junk[31:8], val[7:0]};
    end else begin
      want = {8'd0, val};
      word = {junk[31:24], val};
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ATTACK:  cfg.attack_ticks  = val;
      REG_DECAY:   cfg.decay_ticks   = val;
      REG_SUSTAIN: cfg.sustain_ticks = val;
      REG_RELEASE: cfg.release_ticks = val;
      REG_LEVEL:   cfg.sustain_level = val[7:0];
      default: ;
    endcase
    reg_writes++;
    // read back the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      mismatches++;
      $display("%0t: readback of register %0d: expected %h, actual %h",
               $time, idx, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_cfg(cfg_t c);
    reg_write(REG_ATTACK, c.attack_ticks);
    reg_write(REG_DECAY, c.decay_ticks);
    reg_write(REG_SUSTAIN, c.sustain_ticks);
    reg_write(REG_RELEASE, c.release_ticks);
    reg_write(REG_LEVEL, {16'd0, c.sustain_level});
  endtask

  task automatic send_tick(item_t it, logic typed, result_t want);
    result_t pred;
    int      gap;
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    pred = envelope_step(it);
    expected_levels.push_back(typed ? want : pred);
    tick_count++;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every beat has come back and the block is quiet.
  task automatic wait_results_done();
    item_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_levels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat: expected none, actual amplitude %0d phase %0d",
                 $time, result.amplitude, result.phase);
      end else begin
        level_due = expected_levels.pop_front();
        results_seen++;
        if (result.amplitude !== level_due.amplitude) begin
          mismatches++;
          $display("%0t: amplitude: expected %0d, actual %0d",
                   $time, level_due.amplitude, result.amplitude);
        end
        if (result.phase !== level_due.phase) begin
          mismatches++;
          $display("%0t: phase: expected %0d, actual %0d",
                   $time, level_due.phase, result.phase);
        end
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int kind;
    cfg       = '{24'd1, 24'd1, 24'd0, 24'd1, 8'hFF};
    env_phase = PH_DONE;
    env_ticks = '0;
    env_held  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == RECFG_ROW) begin
        wait_results_done();
        // zero attack time acts as one tick
        program_cfg('{24'd0, 24'd3, 24'd2, 24'd4, 8'h80});
      end
      send_tick(DIR_TABLE[i].tick, DIR_TABLE[i].typed, DIR_TABLE[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_results_done();
      kind = (ph == 2) ? 1 : (ph == 4) ? 2 : (ph == 5 || ph == 7) ? 3 : 0;
      program_cfg(pick_cfg(kind));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 82; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 82; end
        default: begin idle_pct = 15; stall_pct <= 15; end
      endcase
      // long receiver hold-off while ticks keep coming
      if (ph == 2) hold_req <= hold_req + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 6 && n == PHASE_ITEMS / 2) wait_results_done();
        send_tick(pick_tick(), 1'b0, '0);
      end
    end

    wait_results_done();
    if (expected_levels.size() != 0) mismatches++;
    $display("ran %0d ticks through %0d register writes, with idle, stall and hold-off phases",
             tick_count, reg_writes);
    $display("checked %0d result beats, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/adsr_pkg.sv
design/adsr_regs.sv
design/adsr_div.sv
design/adsr_envelope_generator.sv
dv/tb_adsr_envelope_generator.sv
